[rtl/png_chunk_stream_parser_assert.svh]
`ifndef PNG_CHUNK_STREAM_PARSER_ASSERT_SVH
`define PNG_CHUNK_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PCSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define PCSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pcsp_pkg.sv]
package pcsp_pkg;

  localparam logic [31:0] SIG_HI    = 32'h8950_4E47;
  localparam logic [31:0] SIG_LO    = 32'h0D0A_1A0A;
  localparam logic [31:0] CASE_MASK = 32'hDFDF_DFDF;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_PLTE = 32'h504C_5445;
  localparam logic [31:0] TYPE_PHYS = 32'h5048_5953;

  typedef enum logic [5:0] {
    PH_SIG  = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_TYPE = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CRC  = 6'b010000,
    PH_HALT = 6'b100000
  } phase_t;

  typedef enum logic [3:0] {
    EV_SIG_OK     = 4'd0,
    EV_BAD_SIG    = 4'd1,
    EV_HEADER     = 4'd2,
    EV_PALETTE    = 4'd3,
    EV_CHUNK_DONE = 4'd4,
    EV_IHDR_DONE  = 4'd5,
    EV_PHYS_DONE  = 4'd6,
    EV_PAL_ERR    = 4'd7,
    EV_END        = 4'd8
  } ev_kind_t;

  // Running residue mod 3: 4 == 1 (mod 3), so a byte folds into its 2-bit digits
  function automatic logic [1:0] mod3_fold(input logic [7:0] b, input logic [1:0] r);
    logic [3:0] s;
    logic [1:0] m;
    s = 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]) + 4'(r);
    case (s) inside
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: m = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       m = 2'd1;
      default:                              m = 2'd2;
    endcase
    return m;
  endfunction

endpackage

[rtl/png_chunk_stream_parser.sv]
// Channel  | Direction | Handshake             | Payload
// in_      | input     | in_valid / in_ready   | in_data_byte, one file byte
// out_     | output    | out_valid / out_ready | event_kind and chunk fields
//
// One byte is taken per cycle while in_ready is high; state updates in the cycle a byte is taken.
// An event appears on out_ in the cycle after the byte that caused it.
// The output register is the only stall point: in_ready drops only while a
// result is held and out_ready is low.
// Synchronous active-low reset returns to the signature phase; halt is sticky.
module png_chunk_stream_parser
  import pcsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_kind,
  output logic [31:0] out_chunk_type,
  output logic [30:0] out_chunk_length,
  output logic [31:0] out_chunk_crc,
  output logic [31:0] out_word_a,
  output logic [31:0] out_word_b,
  output logic [7:0]  out_bit_depth,
  output logic [7:0]  out_color_kind,
  output logic [7:0]  out_compress_method,
  output logic [7:0]  out_filter_method,
  output logic [7:0]  out_interlace_or_unit,
  output logic [7:0]  out_palette_index
);

  phase_t      phase_r, phase_nxt;
  logic [30:0] cnt_r, cnt_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] cur_type_r, cur_type_nxt;
  logic [30:0] cur_len_r, cur_len_nxt;
  logic [1:0]  len_mod_r, len_mod_nxt;
  logic [31:0] first_r, first_nxt;
  logic [31:0] second_r, second_nxt;
  logic [7:0]  small_r [5];
  logic [7:0]  small_nxt [5];
  logic [15:0] pal_part_r, pal_part_nxt;
  logic [8:0]  pal_cnt_r, pal_cnt_nxt;
  logic [1:0]  pal_ph_r, pal_ph_nxt;
  logic        pal_ok_r, pal_ok_nxt;

  logic        out_valid_r;
  ev_kind_t    ev_r, res_ev;
  logic [31:0] type_o_r, res_type;
  logic [30:0] len_o_r, res_len;
  logic [31:0] crc_o_r, res_crc;
  logic [31:0] wa_r, res_wa;
  logic [31:0] wb_r, res_wb;
  logic [7:0]  f_r [5];
  logic [7:0]  res_f [5];
  logic [7:0]  pidx_r, res_pidx;
  logic        res_valid;

  logic        fire;
  logic [31:0] sh;
  logic [31:0] masked;
  logic        is_ihdr, is_phys, is_plte;
  logic [30:0] cnt_inc;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign sh       = {shift_r[23:0], in_data_byte};
  assign masked   = cur_type_r & CASE_MASK;
  assign is_ihdr  = (masked == TYPE_IHDR);
  assign is_phys  = (masked == TYPE_PHYS);
  assign is_plte  = (masked == TYPE_PLTE);
  assign cnt_inc  = cnt_r + 31'd1;

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    shift_nxt    = shift_r;
    cur_type_nxt = cur_type_r;
    cur_len_nxt  = cur_len_r;
    len_mod_nxt  = len_mod_r;
    first_nxt    = first_r;
    second_nxt   = second_r;
    small_nxt    = small_r;
    pal_part_nxt = pal_part_r;
    pal_cnt_nxt  = pal_cnt_r;
    pal_ph_nxt   = pal_ph_r;
    pal_ok_nxt   = pal_ok_r;
    res_valid    = 1'b0;
    res_ev       = EV_SIG_OK;
    res_type     = '0;
    res_len      = '0;
    res_crc      = '0;
    res_wa       = '0;
    res_wb       = '0;
    res_f        = '{default: 8'd0};
    res_pidx     = '0;

    if (fire) begin
      unique case (phase_r)
        PH_SIG: begin
          shift_nxt = sh;
          cnt_nxt   = cnt_inc;
          if (cnt_r == 31'd3 && sh != SIG_HI) begin
            phase_nxt = PH_HALT;
            res_valid = 1'b1;
            res_ev    = EV_BAD_SIG;
          end else if (cnt_r == 31'd7) begin
            cnt_nxt   = '0;
            res_valid = 1'b1;
            if (sh != SIG_LO) begin
              phase_nxt = PH_HALT;
              res_ev    = EV_BAD_SIG;
            end else begin
              phase_nxt = PH_LEN;
              res_ev    = EV_SIG_OK;
            end
          end
        end
        PH_LEN: begin
          shift_nxt = sh;
          cnt_nxt   = cnt_inc;
          // drop the length's top bit before folding the first byte
          if (cnt_r == 31'd0) begin
            len_mod_nxt = mod3_fold({1'b0, in_data_byte[6:0]}, 2'd0);
          end else begin
            len_mod_nxt = mod3_fold(in_data_byte, len_mod_r);
          end
          if (cnt_r == 31'd3) begin
            cnt_nxt     = '0;
            cur_len_nxt = sh[30:0];
            phase_nxt   = PH_TYPE;
          end
        end
        PH_TYPE: begin
          shift_nxt = sh;
          cnt_nxt   = cnt_inc;
          if (cnt_r == 31'd3) begin
            cnt_nxt      = '0;
            cur_type_nxt = sh;
            first_nxt    = '0;
            second_nxt   = '0;
            small_nxt    = '{default: 8'd0};
            pal_part_nxt = '0;
            pal_ph_nxt   = 2'd0;
            pal_ok_nxt   = (len_mod_r == 2'd0);
            phase_nxt    = (cur_len_r != '0) ? PH_DATA : PH_CRC;
            res_valid    = 1'b1;
            res_ev       = EV_HEADER;
            res_type     = sh;
            res_len      = cur_len_r;
          end
        end
        PH_DATA: begin
          if (is_ihdr || is_phys) begin
            if (cnt_r < 31'd4) begin
              first_nxt = {first_r[23:0], in_data_byte};
            end else if (cnt_r < 31'd8) begin
              second_nxt = {second_r[23:0], in_data_byte};
            end else if (cnt_r <= (is_ihdr ? 31'd12 : 31'd8)) begin
              small_nxt[cnt_r[2:0]] = in_data_byte;
            end
          end else if (is_plte && pal_ok_r) begin
            if (pal_ph_r == 2'd2) begin
              if (!pal_cnt_r[8]) begin
                res_valid   = 1'b1;
                res_ev      = EV_PALETTE;
                res_type    = cur_type_r;
                res_len     = cur_len_r;
                res_wa      = {8'd0, pal_part_r, in_data_byte};
                res_pidx    = pal_cnt_r[7:0];
                pal_cnt_nxt = pal_cnt_r + 9'd1;
              end
              pal_part_nxt = '0;
            end else begin
              pal_part_nxt = {pal_part_r[7:0], in_data_byte};
            end
          end
          pal_ph_nxt = (pal_ph_r == 2'd2) ? 2'd0 : pal_ph_r + 2'd1;
          cnt_nxt    = cnt_inc;
          if (cnt_inc == cur_len_r) begin
            cnt_nxt   = '0;
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          shift_nxt = sh;
          cnt_nxt   = cnt_inc;
          if (cnt_r == 31'd3) begin
            cnt_nxt   = '0;
            phase_nxt = PH_LEN;
            res_valid = 1'b1;
            res_type  = cur_type_r;
            res_len   = cur_len_r;
            res_crc   = sh;
            if (cur_type_r == TYPE_IEND) begin
              phase_nxt = PH_HALT;
              res_ev    = EV_END;
            end else if (is_plte && !pal_ok_r) begin
              phase_nxt = PH_HALT;
              res_ev    = EV_PAL_ERR;
            end else if (is_ihdr) begin
              res_ev = EV_IHDR_DONE;
              res_wa = first_r;
              res_wb = second_r;
              res_f  = small_r;
            end else if (is_phys) begin
              res_ev    = EV_PHYS_DONE;
              res_wa    = first_r;
              res_wb    = second_r;
              res_f[4]  = small_r[0];
            end else begin
              res_ev = EV_CHUNK_DONE;
            end
          end
        end
        PH_HALT: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIG;
      cnt_r       <= '0;
      shift_r     <= '0;
      cur_type_r  <= '0;
      cur_len_r   <= '0;
      len_mod_r   <= '0;
      first_r     <= '0;
      second_r    <= '0;
      small_r     <= '{default: 8'd0};
      pal_part_r  <= '0;
      pal_cnt_r   <= '0;
      pal_ph_r    <= '0;
      pal_ok_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      shift_r    <= shift_nxt;
      cur_type_r <= cur_type_nxt;
      cur_len_r  <= cur_len_nxt;
      len_mod_r  <= len_mod_nxt;
      first_r    <= first_nxt;
      second_r   <= second_nxt;
      small_r    <= small_nxt;
      pal_part_r <= pal_part_nxt;
      pal_cnt_r  <= pal_cnt_nxt;
      pal_ph_r   <= pal_ph_nxt;
      pal_ok_r   <= pal_ok_nxt;
      if (in_ready) begin
        out_valid_r <= fire && res_valid;
      end
    end
  end

  // result payload: load whenever the output slot is free
  always_ff @(posedge clk) begin
    if (in_ready) begin
      ev_r     <= res_ev;
      type_o_r <= res_type;
      len_o_r  <= res_len;
      crc_o_r  <= res_crc;
      wa_r     <= res_wa;
      wb_r     <= res_wb;
      f_r      <= res_f;
      pidx_r   <= res_pidx;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_event_kind        = ev_r;
  assign out_chunk_type        = type_o_r;
  assign out_chunk_length      = len_o_r;
  assign out_chunk_crc         = crc_o_r;
  assign out_word_a            = wa_r;
  assign out_word_b            = wb_r;
  assign out_bit_depth         = f_r[0];
  assign out_color_kind        = f_r[1];
  assign out_compress_method   = f_r[2];
  assign out_filter_method     = f_r[3];
  assign out_interlace_or_unit = f_r[4];
  assign out_palette_index     = pidx_r;

`include "png_chunk_stream_parser_assert.svh"

  `PCSP_ASSERT_NOW(a_phase_onehot, 1'b1, $onehot(phase_r), "phase register not one-hot")
  `PCSP_ASSERT_NEXT(a_halt_sticky, phase_r == PH_HALT, phase_r == PH_HALT, "left halt without reset")
  `PCSP_ASSERT_NOW(a_data_len, phase_r == PH_DATA, cur_len_r != '0, "data phase with zero length")
  `PCSP_ASSERT_NOW(a_pal_rgb, out_valid_r && ev_r == EV_PALETTE, wa_r[31:24] == 8'd0,
    "palette entry wider than 24 bits")

endmodule
